### design/wtsr_pkg.sv
// Shared types, widths and CORDIC constants for the world-to-screen rotator.
`timescale 1ns / 1ps

package wtsr_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_COUNT    = 24;
	localparam int GUARD_BITS    = 8;

	localparam int PT_W    = 32;                 // point and result width
	localparam int SUM_W   = PT_W + 1;           // world plus camera offset
	localparam int FOLD_W  = PT_W + 2;           // room to negate the sum
	localparam int GAIN_W  = 31;                 // Q0.30 gain with a sign bit
	localparam int PROD_W  = FOLD_W + GAIN_W;
	localparam int XY_W    = PT_W + GUARD_BITS + 4;
	localparam int Z_W     = 33;
	localparam int ANG_W   = 16;
	localparam int VIEW_W  = 14;
	localparam int STAGE_W = $clog2(ATAN_COUNT);
	localparam int GAIN_SHIFT = 30 - GUARD_BITS;

	localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

	typedef enum logic [2:0] {
		REG_CAM_X       = 3'd0,
		REG_CAM_Y       = 3'd1,
		REG_CAM_ANGLE   = 3'd2,
		REG_VIEW_WIDTH  = 3'd3,
		REG_VIEW_HEIGHT = 3'd4
	} reg_idx_t;

	// One CORDIC vector in flight between cells.
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} vec_t;

	// Arctangent of 2^-i, 2^32 per full turn, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_of(input logic [STAGE_W-1:0] i);
		logic [31:0] v;
		begin
			case (i)
				5'd0:  v = 32'd536870912;
				5'd1:  v = 32'd316933406;
				5'd2:  v = 32'd167458907;
				5'd3:  v = 32'd85004756;
				5'd4:  v = 32'd42667331;
				5'd5:  v = 32'd21354465;
				5'd6:  v = 32'd10679838;
				5'd7:  v = 32'd5340245;
				5'd8:  v = 32'd2670163;
				5'd9:  v = 32'd1335087;
				5'd10: v = 32'd667544;
				5'd11: v = 32'd333772;
				5'd12: v = 32'd166886;
				5'd13: v = 32'd83443;
				5'd14: v = 32'd41722;
				5'd15: v = 32'd20861;
				5'd16: v = 32'd10430;
				5'd17: v = 32'd5215;
				5'd18: v = 32'd2608;
				5'd19: v = 32'd1304;
				5'd20: v = 32'd652;
				5'd21: v = 32'd326;
				5'd22: v = 32'd163;
				5'd23: v = 32'd81;
				default: v = 32'd0;
			endcase
			atan_of = $signed({1'b0, v});
		end
	endfunction

endpackage

### design/wtsr_front.sv
// Front end: camera offset, half-turn fold and gain compensation.
`timescale 1ns / 1ps

module wtsr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [wtsr_pkg::PT_W-1:0]    world_x,
	input  logic signed [wtsr_pkg::PT_W-1:0]    world_y,
	input  logic signed [wtsr_pkg::PT_W-1:0]    cam_x,
	input  logic signed [wtsr_pkg::PT_W-1:0]    cam_y,
	input  logic        [wtsr_pkg::ANG_W-1:0]   cam_angle,
	output logic                                out_vld,
	output wtsr_pkg::vec_t                      out_vec
);

	logic                                  vld_s1;
	logic signed [wtsr_pkg::SUM_W-1:0]     ox_s1, oy_s1;
	logic                                  flip;
	logic signed [wtsr_pkg::ANG_W-1:0]     ang;
	logic signed [wtsr_pkg::FOLD_W-1:0]    fx, fy;
	logic signed [wtsr_pkg::PROD_W-1:0]    px, py;
	logic signed [wtsr_pkg::PROD_W-1:0]    rnd;
	logic                                  vld_s2;
	wtsr_pkg::vec_t                        vec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ox_s1 <= wtsr_pkg::SUM_W'(world_x) + wtsr_pkg::SUM_W'(cam_x);
		oy_s1 <= wtsr_pkg::SUM_W'(world_y) + wtsr_pkg::SUM_W'(cam_y);
	end

	// Angles in the back half turn: negate the point, shift the angle by half a turn.
	always_comb begin
		flip = (cam_angle[15:14] == 2'b01) || (cam_angle[15:14] == 2'b10);
		ang  = flip ? $signed({~cam_angle[15], cam_angle[14:0]}) : $signed(cam_angle);
		fx   = flip ? -wtsr_pkg::FOLD_W'(ox_s1) : wtsr_pkg::FOLD_W'(ox_s1);
		fy   = flip ? -wtsr_pkg::FOLD_W'(oy_s1) : wtsr_pkg::FOLD_W'(oy_s1);
		rnd  = wtsr_pkg::PROD_W'(1) <<< (wtsr_pkg::GAIN_SHIFT - 1);
		px   = (fx * wtsr_pkg::GAIN_Q30 + rnd) >>> wtsr_pkg::GAIN_SHIFT;
		py   = (fy * wtsr_pkg::GAIN_Q30 + rnd) >>> wtsr_pkg::GAIN_SHIFT;
	end

	// Register the point; scale the binary angle up to the 2^32-per-turn accumulator.
	always_ff @(posedge clk) begin
		vec_s2.x <= px[wtsr_pkg::XY_W-1:0];
		vec_s2.y <= py[wtsr_pkg::XY_W-1:0];
		vec_s2.z <= wtsr_pkg::Z_W'(ang) <<< wtsr_pkg::ANG_W;
	end

	assign out_vld = vld_s2;
	assign out_vec = vec_s2;

endmodule

### design/wtsr_cell.sv
// One CORDIC micro-rotation cell; the index sets its shift and arctangent step.
`timescale 1ns / 1ps

module wtsr_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [wtsr_pkg::STAGE_W-1:0]      idx,
	input  logic                              in_vld,
	input  wtsr_pkg::vec_t                    in_vec,
	output logic                              out_vld,
	output wtsr_pkg::vec_t                    out_vec
);

	logic signed [wtsr_pkg::XY_W-1:0] dx, dy;
	logic signed [wtsr_pkg::Z_W-1:0]  step;
	wtsr_pkg::vec_t                   nxt;
	wtsr_pkg::vec_t                   vec_q;
	logic                             vld_q;

	always_comb begin
		dx   = in_vec.y >>> idx;
		dy   = in_vec.x >>> idx;
		step = wtsr_pkg::atan_of(idx);
		if (!in_vec.z[wtsr_pkg::Z_W-1]) begin
			nxt.x = in_vec.x - dx;
			nxt.y = in_vec.y + dy;
			nxt.z = in_vec.z - step;
		end else begin
			nxt.x = in_vec.x + dx;
			nxt.y = in_vec.y - dy;
			nxt.z = in_vec.z + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= nxt;
	end

	assign out_vld = vld_q;
	assign out_vec = vec_q;

endmodule

### design/wtsr_back.sv
// Back end: drop guard bits, add the view center, flip y and saturate.
`timescale 1ns / 1ps

module wtsr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [wtsr_pkg::XY_W-1:0]    x,
	input  logic signed [wtsr_pkg::XY_W-1:0]    y,
	input  logic        [wtsr_pkg::VIEW_W-1:0]  view_width,
	input  logic        [wtsr_pkg::VIEW_W-1:0]  view_height,
	output logic                                done,
	output logic signed [wtsr_pkg::PT_W-1:0]    screen_x,
	output logic signed [wtsr_pkg::PT_W-1:0]    screen_y,
	output logic                                clipped
);

	localparam logic signed [wtsr_pkg::XY_W-1:0] RND_G =
		wtsr_pkg::XY_W'(1) <<< (wtsr_pkg::GUARD_BITS - 1);
	localparam logic signed [wtsr_pkg::XY_W-1:0] MAX_V =
		wtsr_pkg::XY_W'(2147483647);
	localparam logic signed [wtsr_pkg::XY_W-1:0] MIN_V =
		-(wtsr_pkg::XY_W'(2147483647)) - wtsr_pkg::XY_W'(1);

	logic signed [wtsr_pkg::XY_W-1:0] xr, yr, hw, hh, sx, sy;
	logic                             clip_x, clip_y;
	logic signed [wtsr_pkg::PT_W-1:0] sat_x, sat_y;
	logic                             done_q;
	logic signed [wtsr_pkg::PT_W-1:0] screen_x_q, screen_y_q;
	logic                             clipped_q;

	always_comb begin
		xr = (x + RND_G) >>> wtsr_pkg::GUARD_BITS;
		yr = (y + RND_G) >>> wtsr_pkg::GUARD_BITS;
		hw = wtsr_pkg::XY_W'(view_width >> 1) <<< wtsr_pkg::FRAC_BITS;
		hh = wtsr_pkg::XY_W'(view_height >> 1) <<< wtsr_pkg::FRAC_BITS;
		sx = xr + hw;
		sy = hh - yr;
		clip_x = (sx > MAX_V) || (sx < MIN_V);
		clip_y = (sy > MAX_V) || (sy < MIN_V);
		if (sx > MAX_V) begin
			sat_x = MAX_V[wtsr_pkg::PT_W-1:0];
		end else if (sx < MIN_V) begin
			sat_x = MIN_V[wtsr_pkg::PT_W-1:0];
		end else begin
			sat_x = sx[wtsr_pkg::PT_W-1:0];
		end
		if (sy > MAX_V) begin
			sat_y = MAX_V[wtsr_pkg::PT_W-1:0];
		end else if (sy < MIN_V) begin
			sat_y = MIN_V[wtsr_pkg::PT_W-1:0];
		end else begin
			sat_y = sy[wtsr_pkg::PT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		screen_x_q <= sat_x;
		screen_y_q <= sat_y;
		clipped_q  <= clip_x | clip_y;
	end

	assign done     = done_q;
	assign screen_x = screen_x_q;
	assign screen_y = screen_y_q;
	assign clipped  = clipped_q;

endmodule

### design/world_to_screen_rotate.sv
// Top level of the world-to-screen rotator: config registers and the CORDIC cell chain.
`timescale 1ns / 1ps
//
// Maps a world point (signed Q16.16) to screen coordinates: adds the camera
// offset, rotates by the camera angle through a row of CORDIC cells, adds
// half the view width to x and subtracts rotated y from half the view height.
// Inputs: pulse start with world_x/world_y; busy is always low, so a point is
// taken every cycle. Results: done strobes for one cycle with screen_x,
// screen_y and clipped once the point has passed two front stages, one
// register per CORDIC cell and one output stage.
// Throughput is one point per clock; every cell registers its vector.
// Results cannot be held off; the receiver must take each done beat.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write config only while no point is in flight.
// Reset clears the pipeline valid bits and loads camera 0,0, angle 0 and a
// 640 by 480 view.
//

module world_to_screen_rotate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [wtsr_pkg::PT_W-1:0]    world_x,
	input  logic signed [wtsr_pkg::PT_W-1:0]    world_y,
	output logic                                done,
	output logic signed [wtsr_pkg::PT_W-1:0]    screen_x,
	output logic signed [wtsr_pkg::PT_W-1:0]    screen_y,
	output logic                                clipped,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [31:0]                         cfg_data
);

	logic signed [wtsr_pkg::PT_W-1:0]   cam_x_q, cam_y_q;
	logic        [wtsr_pkg::ANG_W-1:0]  cam_angle_q;
	logic        [wtsr_pkg::VIEW_W-1:0] view_width_q, view_height_q;

	logic           vld_chain [wtsr_pkg::CORDIC_STAGES+1];
	wtsr_pkg::vec_t vec_chain [wtsr_pkg::CORDIC_STAGES+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q       <= '0;
			cam_y_q       <= '0;
			cam_angle_q   <= '0;
			view_width_q  <= wtsr_pkg::VIEW_W'(640);
			view_height_q <= wtsr_pkg::VIEW_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			case (wtsr_pkg::reg_idx_t'(cfg_index))
				wtsr_pkg::REG_CAM_X:       cam_x_q       <= cfg_data;
				wtsr_pkg::REG_CAM_Y:       cam_y_q       <= cfg_data;
				wtsr_pkg::REG_CAM_ANGLE:   cam_angle_q   <= cfg_data[wtsr_pkg::ANG_W-1:0];
				wtsr_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_data[wtsr_pkg::VIEW_W-1:0];
				wtsr_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_data[wtsr_pkg::VIEW_W-1:0];
				default: ;
			endcase
		end
	end

	wtsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start && !busy),
		.world_x   (world_x),
		.world_y   (world_y),
		.cam_x     (cam_x_q),
		.cam_y     (cam_y_q),
		.cam_angle (cam_angle_q),
		.out_vld   (vld_chain[0]),
		.out_vec   (vec_chain[0])
	);

	for (genvar g = 0; g < wtsr_pkg::CORDIC_STAGES; g++) begin : g_cell
		wtsr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (wtsr_pkg::STAGE_W'(g)),
			.in_vld  (vld_chain[g]),
			.in_vec  (vec_chain[g]),
			.out_vld (vld_chain[g+1]),
			.out_vec (vec_chain[g+1])
		);
	end

	wtsr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_chain[wtsr_pkg::CORDIC_STAGES]),
		.x           (vec_chain[wtsr_pkg::CORDIC_STAGES].x),
		.y           (vec_chain[wtsr_pkg::CORDIC_STAGES].y),
		.view_width  (view_width_q),
		.view_height (view_height_q),
		.done        (done),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.clipped     (clipped)
	);

endmodule

### test/world_to_screen_rotate_tb.sv
// Self-checking bench for world_to_screen_rotate: random points across camera settings.
`timescale 1ns / 1ps

module world_to_screen_rotate_tb;
	import wtsr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_FROM  = 2000;
	localparam int QUIET_TO    = 4500;

	localparam logic signed [PT_W-1:0] P_MAX = 32'sh7fffffff;
	localparam logic signed [PT_W-1:0] P_MIN = 32'sh80000000;
	localparam logic signed [PT_W-1:0] P_ONE = 32'sh00010000;

	localparam longint QUARTER_TURN = 16384;
	localparam longint HALF_TURN    = 32768;
	localparam longint THREE_QUART  = 49152;
	localparam longint FULL_TURN    = 65536;
	localparam longint Z_PER_UNIT   = 65536;
	localparam longint ROUND_GAIN   = longint'(1) << (GAIN_SHIFT - 1);
	localparam longint ROUND_GUARD  = longint'(1) << (GUARD_BITS - 1);
	localparam longint SAT_HI       = 2147483647;
	localparam longint SAT_LO       = -SAT_HI - 1;

	localparam logic [2:0] IDX_SPARE_LO = 3'(REG_VIEW_HEIGHT + 1);
	localparam logic [2:0] IDX_SPARE_HI = 3'b111;

	typedef struct packed {
		logic                   is_cfg;
		logic [2:0]             idx;
		logic [31:0]            data;
		logic signed [PT_W-1:0] wx;
		logic signed [PT_W-1:0] wy;
	} job_t;

	typedef struct packed {
		logic signed [PT_W-1:0] sx;
		logic signed [PT_W-1:0] sy;
		logic                   clip;
	} screen_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic signed [PT_W-1:0] world_x   = '0;
	logic signed [PT_W-1:0] world_y   = '0;
	logic                   cfg_valid = 1'b0;
	logic [2:0]             cfg_index = '0;
	logic [31:0]            cfg_data  = '0;
	logic                   busy;
	logic                   done;
	logic signed [PT_W-1:0] screen_x;
	logic signed [PT_W-1:0] screen_y;
	logic                   clipped;
	logic                   cfg_ready;

	world_to_screen_rotate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.world_x   (world_x),
		.world_y   (world_y),
		.done      (done),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.clipped   (clipped),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Camera and view as the bench believes them to be.
	logic signed [PT_W-1:0] cam_x_m     = '0;
	logic signed [PT_W-1:0] cam_y_m     = '0;
	logic [ANG_W-1:0]       cam_angle_m = '0;
	logic [VIEW_W-1:0]      view_w_m    = 14'd640;
	logic [VIEW_W-1:0]      view_h_m    = 14'd480;

	longint atan_tbl [0:ATAN_COUNT-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	job_t        job_q [$];
	screen_t     due_q [$];
	int unsigned n_issued = 0;
	int unsigned n_done   = 0;
	int unsigned errors   = 0;
	int unsigned cyc      = 0;

	function automatic screen_t map_to_screen(input logic signed [PT_W-1:0] wx,
			input logic signed [PT_W-1:0] wy);
		screen_t r;
		longint  ox, oy, ang, x, y, z, dx, dy, vx, vy;
		ox  = longint'(wx) + longint'(cam_x_m);
		oy  = longint'(wy) + longint'(cam_y_m);
		ang = longint'(cam_angle_m);
		// fold the back half-plane so the CORDIC sees +/- 90 degrees only
		if (ang >= QUARTER_TURN && ang < THREE_QUART) begin
			ox  = -ox;
			oy  = -oy;
			ang = ang - HALF_TURN;
		end else if (ang >= THREE_QUART) begin
			ang = ang - FULL_TURN;
		end
		x = (ox * longint'(GAIN_Q30) + ROUND_GAIN) >>> GAIN_SHIFT;
		y = (oy * longint'(GAIN_Q30) + ROUND_GAIN) >>> GAIN_SHIFT;
		z = ang * Z_PER_UNIT;
		for (int i = 0; i < CORDIC_STAGES && i < ATAN_COUNT; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_tbl[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_tbl[i];
			end
		end
		x  = (x + ROUND_GUARD) >>> GUARD_BITS;
		y  = (y + ROUND_GUARD) >>> GUARD_BITS;
		vx = x + (longint'(view_w_m >> 1) << FRAC_BITS);
		vy = (longint'(view_h_m >> 1) << FRAC_BITS) - y;
		r.clip = 1'b0;
		if (vx > SAT_HI) begin
			vx = SAT_HI;
			r.clip = 1'b1;
		end else if (vx < SAT_LO) begin
			vx = SAT_LO;
			r.clip = 1'b1;
		end
		if (vy > SAT_HI) begin
			vy = SAT_HI;
			r.clip = 1'b1;
		end else if (vy < SAT_LO) begin
			vy = SAT_LO;
			r.clip = 1'b1;
		end
		r.sx = vx[PT_W-1:0];
		r.sy = vy[PT_W-1:0];
		return r;
	endfunction

	task automatic add_point(input logic signed [PT_W-1:0] wx, input logic signed [PT_W-1:0] wy);
		job_t j;
		j = '0;
		j.wx = wx;
		j.wy = wy;
		job_q.push_back(j);
	endtask

	task automatic add_cfg(input logic [2:0] idx, input logic [31:0] data);
		job_t j;
		j = '0;
		j.is_cfg = 1'b1;
		j.idx    = idx;
		j.data   = data;
		job_q.push_back(j);
	endtask

	// Mostly small values near the origin, with extremes and full-range noise.
	function automatic logic signed [PT_W-1:0] rand_coord();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0:       return P_MAX;
			1:       return P_MIN;
			2:       return '0;
			3, 4:    return r;
			default: return {{8{r[23]}}, r[23:0]};
		endcase
	endfunction

	function automatic logic [31:0] rand_view();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'd8192;
			3:       return $urandom_range(16383, 8193);
			4:       return $urandom;
			default: return $urandom_range(8192, 1);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("** world_to_screen_rotate: FAILED **");
			$finish;
		end
	end

	// Driver: retire the beat just taken, then offer the next job.
	always @(posedge clk or negedge arst_n) begin : drive
		job_t        head;
		screen_t     due;
		int unsigned issued_now;
		logic        hold, offer_pt, offer_cfg;
		if (!arst_n) begin
			start     <= 1'b0;
			world_x   <= '0;
			world_y   <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
		end else begin
			issued_now = n_issued;
			if (start && !busy) begin
				head = job_q.pop_front();
				due  = map_to_screen(head.wx, head.wy);
				due_q.push_back(due);
				issued_now++;
			end
			if (cfg_valid && cfg_ready) begin
				head = job_q.pop_front();
				case (head.idx)
					REG_CAM_X:       cam_x_m     = head.data;
					REG_CAM_Y:       cam_y_m     = head.data;
					REG_CAM_ANGLE:   cam_angle_m = head.data[ANG_W-1:0];
					REG_VIEW_WIDTH:  view_w_m    = head.data[VIEW_W-1:0];
					REG_VIEW_HEIGHT: view_h_m    = head.data[VIEW_W-1:0];
					default: ;
				endcase
			end
			n_issued <= issued_now;
			hold = !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < 6);
			offer_pt  = 1'b0;
			offer_cfg = 1'b0;
			if (job_q.size() != 0 && !hold) begin
				if (!job_q[0].is_cfg)
					offer_pt = 1'b1;
				else if (issued_now == n_done)
					offer_cfg = 1'b1;   // pipeline empty: safe to retune
			end
			start     <= offer_pt;
			cfg_valid <= offer_cfg;
			if (offer_pt) begin
				world_x <= job_q[0].wx;
				world_y <= job_q[0].wy;
			end
			if (offer_cfg) begin
				cfg_index <= job_q[0].idx;
				cfg_data  <= job_q[0].data;
			end
		end
	end

	// Monitor: every done beat must match the oldest prediction.
	always @(posedge clk) begin : check
		screen_t want;
		if (arst_n && done) begin
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: x %h y %h clip %b",
					$time, screen_x, screen_y, clipped);
			end else begin
				want = due_q.pop_front();
				if (screen_x !== want.sx) begin
					errors++;
					$display("%0t: screen_x expected %h got %h", $time, want.sx, screen_x);
				end
				if (screen_y !== want.sy) begin
					errors++;
					$display("%0t: screen_y expected %h got %h", $time, want.sy, screen_y);
				end
				if (clipped !== want.clip) begin
					errors++;
					$display("%0t: clipped expected %b got %b", $time, want.clip, clipped);
				end
				n_done <= n_done + 1;
			end
		end
	end

	initial begin : run
		int          n;
		logic [31:0] r;
		logic [15:0] ang;

		// reset settings, corner points
		add_point('0, '0);
		add_point(P_MAX, P_MAX);
		add_point(P_MIN, P_MIN);
		add_point(P_MAX, P_MIN);
		add_point(P_MIN, P_MAX);
		add_point(1, -1);

		// extreme offsets, angle right at the fold, zero width, junk above the fields
		add_cfg(REG_CAM_X, P_MAX);
		add_cfg(REG_CAM_Y, P_MIN);
		add_cfg(REG_CAM_ANGLE, 32'hABCD_4000);
		add_cfg(REG_VIEW_WIDTH, 32'd0);
		add_cfg(REG_VIEW_HEIGHT, 32'hFFFF_FFFF);
		add_cfg(IDX_SPARE_LO, 32'hFFFF_FFFF);
		add_cfg(IDX_SPARE_HI, 32'h0000_0000);
		add_point(P_MAX, P_MAX);
		add_point(P_MIN, P_MIN);
		add_point('0, '0);
		add_point(P_MIN, P_MAX);

		add_cfg(REG_CAM_X, P_MIN);
		add_cfg(REG_CAM_Y, P_MAX);
		add_cfg(REG_CAM_ANGLE, 32'(THREE_QUART));
		add_cfg(REG_VIEW_WIDTH, 32'd8192);
		add_cfg(REG_VIEW_HEIGHT, 32'd1);
		add_point(P_MIN, P_MIN);
		add_point(P_MAX, P_MAX);
		add_point(P_MAX, P_MIN);
		add_point('0, '0);

		add_cfg(REG_CAM_X, '0);
		add_cfg(REG_CAM_Y, '0);
		add_cfg(REG_CAM_ANGLE, 32'(HALF_TURN));
		add_cfg(REG_VIEW_WIDTH, 32'd640);
		add_cfg(REG_VIEW_HEIGHT, 32'd480);
		add_point(P_MAX, '0);
		add_point('0, P_MIN);
		add_point(P_ONE, P_ONE);

		// one step below each fold boundary and below the full turn
		add_cfg(REG_CAM_ANGLE, 32'(QUARTER_TURN - 1));
		add_point(P_MAX, P_MAX);
		add_cfg(REG_CAM_ANGLE, 32'(THREE_QUART - 1));
		add_point(P_MAX, P_MAX);
		add_cfg(REG_CAM_ANGLE, 32'(FULL_TURN - 1));
		add_point(P_MIN, P_MIN);

		n = 0;
		while (n < 1900) begin
			r = $urandom;
			if ($urandom_range(0, 3) == 0)
				ang = 16'(QUARTER_TURN * $urandom_range(0, 4) + $urandom_range(0, 2) - 1);
			else
				ang = r[15:0];
			add_cfg(REG_CAM_ANGLE, {16'($urandom_range(65535, 0)), ang});
			if ($urandom_range(0, 1))
				add_cfg(REG_CAM_X, rand_coord());
			if ($urandom_range(0, 1))
				add_cfg(REG_CAM_Y, rand_coord());
			if ($urandom_range(0, 1))
				add_cfg(REG_VIEW_WIDTH, rand_view());
			if ($urandom_range(0, 1))
				add_cfg(REG_VIEW_HEIGHT, rand_view());
			if ($urandom_range(0, 7) == 0)
				add_cfg(3'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)), $urandom);
			repeat ($urandom_range(140, 60)) begin
				add_point(rand_coord(), rand_coord());
				n++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (job_q.size() != 0 || due_q.size() != 0)
			@(posedge clk);
		// drop out only after the pipeline has had time to show any stray beat
		repeat (CORDIC_STAGES + 8) @(posedge clk);
		if (errors == 0)
			$display("** world_to_screen_rotate: PASSED **");
		else
			$display("** world_to_screen_rotate: FAILED **");
		$finish;
	end

endmodule
